FILE: rtl/owm_pkg.sv
// owm_pkg: shared types, phase and opcode codes, register indexes and
// register reset values for the one-wire bus master.
// No dependencies.
`default_nettype none

package owm_pkg;

  // Widths
  localparam int unsigned COUNT_W  = 10;  // tick counter and duration registers
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned NUM_CFG  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Command codes carried with a tick
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Bus phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REST  = 4'd8
  } phase_t;

  // Duration register indexes
  typedef enum logic [2:0] {
    REG_RESET_LOW    = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_WRITE_START  = 3'd3,
    REG_WRITE_HOLD   = 3'd4,
    REG_READ_LOW     = 3'd5,
    REG_READ_WAIT    = 3'd6,
    REG_READ_REST    = 3'd7
  } cfg_reg_t;

  typedef logic [NUM_CFG-1:0][COUNT_W-1:0] cfg_bank_t;

  // Input beat: one tick
  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] write_data;
    logic              line_level;
  } in_item_t;

  // Result beat: one per tick
  typedef struct packed {
    logic              line_release;
    logic              busy_res;
    logic              done_res;
    logic              presence_bit;
    logic [BYTE_W-1:0] read_data;
  } out_item_t;

  // Reset value of each duration register
  function automatic logic [COUNT_W-1:0] cfg_reset_value(input cfg_reg_t idx);
    logic [COUNT_W-1:0] v;
    case (idx)
      REG_RESET_LOW:     v = COUNT_W'(500);
      REG_PRESENCE_WAIT: v = COUNT_W'(70);
      REG_RESET_RECOVER: v = COUNT_W'(500);
      REG_WRITE_START:   v = COUNT_W'(10);
      REG_WRITE_HOLD:    v = COUNT_W'(50);
      REG_READ_LOW:      v = COUNT_W'(5);
      REG_READ_WAIT:     v = COUNT_W'(5);
      REG_READ_REST:     v = COUNT_W'(50);
      default:           v = COUNT_W'(1);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/owm_cfg_regs.sv
// owm_cfg_regs: the eight slot duration registers with their write port.
// Depends on owm_pkg.
`default_nettype none

module owm_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [owm_pkg::COUNT_W-1:0]   cfg_data,
  output owm_pkg::cfg_bank_t                 cfg_bank
);

  owm_pkg::cfg_bank_t regs_r;

  // Register file: reset loads the default durations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owm_pkg::NUM_CFG; i++) begin
        regs_r[i] <= owm_pkg::cfg_reset_value(owm_pkg::cfg_reg_t'(i));
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  assign cfg_bank = regs_r;

endmodule

`default_nettype wire

FILE: rtl/owm_core.sv
// owm_core: bus phase sequencer. Holds phase, tick counter, bit index,
// shift byte, presence and read byte; steps once per accepted tick.
// Depends on owm_pkg.
`default_nettype none

module owm_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,      // a tick beat is taken this cycle
  input  wire owm_pkg::in_item_t   item,
  input  wire owm_pkg::cfg_bank_t  cfg_bank,
  output owm_pkg::out_item_t       result     // result of the tick being taken
);

  owm_pkg::phase_t                   phase_r, phase_nxt;
  logic [owm_pkg::COUNT_W-1:0]       tick_r, tick_nxt;
  logic [owm_pkg::BIT_IDX_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [owm_pkg::BYTE_W-1:0]        shift_r, shift_nxt;
  logic                              presence_r, presence_nxt;
  logic [owm_pkg::BYTE_W-1:0]        rd_byte_r, rd_byte_nxt;

  logic [owm_pkg::COUNT_W-1:0]       limit;
  logic [owm_pkg::COUNT_W-1:0]       tick_inc;
  logic [owm_pkg::BIT_IDX_W:0]       bit_inc;
  logic                              drive;
  logic                              done;

  // Phase in effect for this tick: a command from idle starts its first phase
  function automatic owm_pkg::phase_t phase_nxt_start(input owm_pkg::phase_t ph,
                                                      input logic [1:0] op);
    owm_pkg::phase_t p;
    p = ph;
    if (ph == owm_pkg::PH_IDLE) begin
      case (op)
        owm_pkg::OP_RESET: p = owm_pkg::PH_RST_LOW;
        owm_pkg::OP_WRITE: p = owm_pkg::PH_WR_LOW;
        owm_pkg::OP_READ:  p = owm_pkg::PH_RD_LOW;
        default:           p = owm_pkg::PH_IDLE;
      endcase
    end
    return p;
  endfunction

  // Duration of the current phase; zero acts as one tick
  always_comb begin
    case (phase_nxt_start(phase_r, item.opcode))
      owm_pkg::PH_RST_LOW:  limit = cfg_bank[owm_pkg::REG_RESET_LOW];
      owm_pkg::PH_RST_WAIT: limit = cfg_bank[owm_pkg::REG_PRESENCE_WAIT];
      owm_pkg::PH_RST_REC:  limit = cfg_bank[owm_pkg::REG_RESET_RECOVER];
      owm_pkg::PH_WR_LOW:   limit = cfg_bank[owm_pkg::REG_WRITE_START];
      owm_pkg::PH_WR_HOLD:  limit = cfg_bank[owm_pkg::REG_WRITE_HOLD];
      owm_pkg::PH_RD_LOW:   limit = cfg_bank[owm_pkg::REG_READ_LOW];
      owm_pkg::PH_RD_WAIT:  limit = cfg_bank[owm_pkg::REG_READ_WAIT];
      owm_pkg::PH_RD_REST:  limit = cfg_bank[owm_pkg::REG_READ_REST];
      default:              limit = '0;
    endcase
    if (limit == '0) begin
      limit = owm_pkg::COUNT_W'(1);
    end
  end

  // One tick of the sequencer
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    presence_nxt = presence_r;
    rd_byte_nxt  = rd_byte_r;
    drive        = 1'b1;
    done         = 1'b0;

    // command start, ignored while busy
    if (phase_r == owm_pkg::PH_IDLE && item.opcode != owm_pkg::OP_NONE) begin
      tick_nxt    = '0;
      bit_idx_nxt = '0;
      phase_nxt   = phase_nxt_start(phase_r, item.opcode);
      if (item.opcode == owm_pkg::OP_WRITE) begin
        shift_nxt = item.write_data;
      end else if (item.opcode == owm_pkg::OP_READ) begin
        shift_nxt = '0;
      end
    end

    tick_inc = tick_nxt + owm_pkg::COUNT_W'(1);
    bit_inc  = {1'b0, bit_idx_nxt} + (owm_pkg::BIT_IDX_W+1)'(1);

    if (phase_nxt != owm_pkg::PH_IDLE) begin
      // line drive of the active phase
      case (phase_nxt)
        owm_pkg::PH_RST_LOW,
        owm_pkg::PH_WR_LOW,
        owm_pkg::PH_RD_LOW:  drive = 1'b0;
        owm_pkg::PH_WR_HOLD: drive = shift_nxt[0];
        default:             drive = 1'b1;
      endcase

      if (tick_inc >= limit) begin
        tick_nxt = '0;
        case (phase_nxt)
          owm_pkg::PH_RST_LOW: phase_nxt = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: begin
            presence_nxt = item.line_level;
            phase_nxt    = owm_pkg::PH_RST_REC;
          end
          owm_pkg::PH_WR_LOW: phase_nxt = owm_pkg::PH_WR_HOLD;
          owm_pkg::PH_WR_HOLD: begin
            shift_nxt = shift_nxt >> 1;
            if (bit_inc[owm_pkg::BIT_IDX_W]) begin
              bit_idx_nxt = '0;
              phase_nxt   = owm_pkg::PH_IDLE;
              done        = 1'b1;
            end else begin
              bit_idx_nxt = bit_inc[owm_pkg::BIT_IDX_W-1:0];
              phase_nxt   = owm_pkg::PH_WR_LOW;
            end
          end
          owm_pkg::PH_RD_LOW: phase_nxt = owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_RD_WAIT: begin
            shift_nxt = {item.line_level, shift_nxt[owm_pkg::BYTE_W-1:1]};
            phase_nxt = owm_pkg::PH_RD_REST;
          end
          owm_pkg::PH_RD_REST: begin
            if (bit_inc[owm_pkg::BIT_IDX_W]) begin
              bit_idx_nxt = '0;
              rd_byte_nxt = shift_nxt;
              phase_nxt   = owm_pkg::PH_IDLE;
              done        = 1'b1;
            end else begin
              bit_idx_nxt = bit_inc[owm_pkg::BIT_IDX_W-1:0];
              phase_nxt   = owm_pkg::PH_RD_LOW;
            end
          end
          default: begin  // reset recovery ends
            phase_nxt = owm_pkg::PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end else begin
        tick_nxt = tick_inc;
      end
    end

    result.line_release = drive;
    result.busy_res     = (phase_nxt != owm_pkg::PH_IDLE);
    result.done_res     = done;
    result.presence_bit = presence_nxt;
    result.read_data    = rd_byte_nxt;
  end

  // Sequencer state, advanced on every taken tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= owm_pkg::PH_IDLE;
      tick_r     <= '0;
      bit_idx_r  <= '0;
      shift_r    <= '0;
      presence_r <= 1'b1;
      rd_byte_r  <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_idx_r  <= bit_idx_nxt;
      shift_r    <= shift_nxt;
      presence_r <= presence_nxt;
      rd_byte_r  <= rd_byte_nxt;
    end
  end

  // Checks
  a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == owm_pkg::PH_IDLE |-> tick_r == '0 && bit_idx_r == '0)
    else $error("idle with live counters");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.done_res |=> phase_r == owm_pkg::PH_IDLE)
    else $error("done without returning to idle");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(tick_r) && $stable(shift_r))
    else $error("state moved without a tick");

endmodule

`default_nettype wire

FILE: rtl/one_wire_master.sv
// one_wire_master: top level of the tick-driven one-wire bus master.
// Depends on owm_pkg, owm_cfg_regs and owm_core.
//
//   channel | direction | handshake            | beat
//   in_     | input     | in_valid / in_ready  | owm_pkg::in_item_t, one tick
//   out_    | output    | out_valid / out_ready| owm_pkg::out_item_t, one per tick
//   cfg_    | input     | cfg_we               | duration register write
//
// The sequencer steps as a tick beat is taken and the beat's result lands in
// the output register on the same edge.
// Sustained rate is one beat per cycle while out_ready keeps results drained.
// The output register is refilled in the cycle it is drained, so a stall on
// out_ready stops in_ready only while the result is not taken.
// Synchronous active-low reset idles the bus and loads default durations.
`default_nettype none

module one_wire_master (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire owm_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output owm_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [owm_pkg::COUNT_W-1:0]   cfg_data
);

  owm_pkg::cfg_bank_t  cfg_bank;
  owm_pkg::out_item_t  result;
  owm_pkg::out_item_t  out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_bank  (cfg_bank)
  );

  owm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_fire),
    .item     (in_data),
    .cfg_bank (cfg_bank),
    .result   (result)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("taken beat produced no result");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done result still busy");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_fire)
    else $error("beat taken over a pending result");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for one_wire_master, with a tick-level bus predictor,
// a queue-fed input driver and a result monitor with random stalls.
// Depends on owm_pkg and the one_wire_master RTL.

module tb;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned RANDOM_TICKS = 200;
  localparam int unsigned SEGMENT_TICKS = 100;

  // Line level patterns for a command and its trailing ticks
  localparam int LVL_LOW  = 0;
  localparam int LVL_HIGH = 1;
  localparam int LVL_RAND = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  owm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  owm_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [owm_pkg::COUNT_W-1:0] cfg_data = '0;

  one_wire_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bus master shadow state and duration registers
  owm_pkg::phase_t bus_phase;
  logic [owm_pkg::COUNT_W-1:0] tick_cnt;
  logic [3:0] bit_cnt;
  logic [owm_pkg::BYTE_W-1:0] shift_reg;
  logic presence_q;
  logic [owm_pkg::BYTE_W-1:0] read_byte;
  logic [owm_pkg::COUNT_W-1:0] dur_cfg [owm_pkg::NUM_CFG];

  owm_pkg::in_item_t tick_backlog [$];
  owm_pkg::out_item_t due_results [$];
  owm_pkg::out_item_t want_beat;

  int unsigned ticks_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gen_busy_left = 0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int unsigned feed_wait = 0;
  int unsigned feed_run = 0;
  bit feed_calm = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned sink_run = 0;
  bit sink_calm = 1'b0;
  int unsigned sink_beats = 0;

  // Duration of a phase in ticks; zero counts as one tick
  function automatic logic [owm_pkg::COUNT_W-1:0] slot_len(input owm_pkg::phase_t ph);
    logic [owm_pkg::COUNT_W-1:0] d;
    d = owm_pkg::COUNT_W'(1);
    if (ph != owm_pkg::PH_IDLE && ph <= owm_pkg::PH_RD_REST)
      d = dur_cfg[int'(ph) - 1];
    if (d == 0)
      d = owm_pkg::COUNT_W'(1);
    return d;
  endfunction

  // Ticks from the start of a command to its done pulse
  function automatic int unsigned cmd_ticks(input owm_pkg::opcode_t op);
    int unsigned n;
    case (op)
      owm_pkg::OP_RESET:
        n = int'(slot_len(owm_pkg::PH_RST_LOW)) + int'(slot_len(owm_pkg::PH_RST_WAIT))
            + int'(slot_len(owm_pkg::PH_RST_REC));
      owm_pkg::OP_WRITE:
        n = owm_pkg::BYTE_W * (int'(slot_len(owm_pkg::PH_WR_LOW))
            + int'(slot_len(owm_pkg::PH_WR_HOLD)));
      owm_pkg::OP_READ:
        n = owm_pkg::BYTE_W * (int'(slot_len(owm_pkg::PH_RD_LOW))
            + int'(slot_len(owm_pkg::PH_RD_WAIT)) + int'(slot_len(owm_pkg::PH_RD_REST)));
      default:
        n = 0;
    endcase
    return n;
  endfunction

  // One bus tick: advance the shadow master and return its result beat
  function automatic owm_pkg::out_item_t master_tick(input owm_pkg::in_item_t t);
    owm_pkg::out_item_t r;
    logic drive;
    logic done;
    drive = 1'b1;
    done = 1'b0;
    if (bus_phase == owm_pkg::PH_IDLE && t.opcode != owm_pkg::OP_NONE) begin
      tick_cnt = '0;
      bit_cnt = '0;
      case (t.opcode)
        owm_pkg::OP_RESET: bus_phase = owm_pkg::PH_RST_LOW;
        owm_pkg::OP_WRITE: begin
          bus_phase = owm_pkg::PH_WR_LOW;
          shift_reg = t.write_data;
        end
        default: begin
          bus_phase = owm_pkg::PH_RD_LOW;
          shift_reg = '0;
        end
      endcase
    end
    if (bus_phase != owm_pkg::PH_IDLE) begin
      case (bus_phase)
        owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW: drive = 1'b0;
        owm_pkg::PH_WR_HOLD: drive = shift_reg[0];
        default: drive = 1'b1;
      endcase
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= slot_len(bus_phase)) begin
        tick_cnt = '0;
        case (bus_phase)
          owm_pkg::PH_RST_LOW: bus_phase = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: begin
            presence_q = t.line_level;
            bus_phase = owm_pkg::PH_RST_REC;
          end
          owm_pkg::PH_WR_LOW: bus_phase = owm_pkg::PH_WR_HOLD;
          owm_pkg::PH_WR_HOLD: begin
            shift_reg = shift_reg >> 1;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= owm_pkg::BYTE_W) begin
              bit_cnt = '0;
              bus_phase = owm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              bus_phase = owm_pkg::PH_WR_LOW;
            end
          end
          owm_pkg::PH_RD_LOW: bus_phase = owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_RD_WAIT: begin
            shift_reg = {t.line_level, shift_reg[owm_pkg::BYTE_W-1:1]};
            bus_phase = owm_pkg::PH_RD_REST;
          end
          owm_pkg::PH_RD_REST: begin
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= owm_pkg::BYTE_W) begin
              bit_cnt = '0;
              read_byte = shift_reg;
              bus_phase = owm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              bus_phase = owm_pkg::PH_RD_LOW;
            end
          end
          // end of reset recovery
          default: begin
            bus_phase = owm_pkg::PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
    r.line_release = drive;
    r.busy_res = (bus_phase != owm_pkg::PH_IDLE);
    r.done_res = done;
    r.presence_bit = presence_q;
    r.read_data = read_byte;
    return r;
  endfunction

  function automatic int unsigned pick_wait();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
  endfunction

  function automatic logic line_for(input int mode);
    if (mode == LVL_LOW)
      return 1'b0;
    if (mode == LVL_HIGH)
      return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // Queue one tick; track how long the bus stays busy so sequences line up
  function automatic void add_tick(input owm_pkg::opcode_t op,
                                   input logic [owm_pkg::BYTE_W-1:0] d,
                                   input logic lvl);
    owm_pkg::in_item_t t;
    t.opcode = op;
    t.write_data = d;
    t.line_level = lvl;
    tick_backlog.push_back(t);
    ticks_sent++;
    if (gen_busy_left == 0 && op != owm_pkg::OP_NONE)
      gen_busy_left = cmd_ticks(op);
    if (gen_busy_left > 0)
      gen_busy_left--;
  endfunction

  // Fill the rest of a running command; stray commands here are ignored
  function automatic void finish_busy(input int mode);
    owm_pkg::opcode_t op;
    while (gen_busy_left > 0) begin
      op = ($urandom_range(0, 3) == 0) ? owm_pkg::opcode_t'($urandom_range(0, 3))
                                       : owm_pkg::OP_NONE;
      add_tick(op, owm_pkg::BYTE_W'($urandom), line_for(mode));
    end
  endfunction

  function automatic void run_command(input owm_pkg::opcode_t op,
                                      input logic [owm_pkg::BYTE_W-1:0] d,
                                      input int mode);
    add_tick(op, d, line_for(mode));
    finish_busy(mode);
  endfunction

  // Random opcodes with no framing, then let the bus go idle
  function automatic void noise_burst();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) add_tick(owm_pkg::opcode_t'($urandom_range(0, 3)),
                        owm_pkg::BYTE_W'($urandom), 1'($urandom_range(0, 1)));
    finish_busy(LVL_RAND);
  endfunction

  function automatic logic [owm_pkg::COUNT_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return '0;
    if (r <= 2)
      return owm_pkg::COUNT_W'($urandom_range(4, 12));
    return owm_pkg::COUNT_W'($urandom_range(1, 3));
  endfunction

  task automatic set_duration(input owm_pkg::cfg_reg_t idx,
                              input logic [owm_pkg::COUNT_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    dur_cfg[idx] = v;
  endtask

  // Block until every queued tick has produced its checked result
  task automatic wait_quiet();
    do @(negedge clk); while (beats_checked != ticks_sent);
    repeat (4) @(negedge clk);
  endtask

  function automatic void flag_field(input string field,
                                     input logic [owm_pkg::BYTE_W-1:0] want_v,
                                     input logic [owm_pkg::BYTE_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
  endfunction

  // Input driver: one tick beat per handshake, random gaps between beats
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_took) begin
        if (feed_run == 0) begin
          feed_run = $urandom_range(8, 64);
          feed_calm = ($urandom_range(0, 3) == 0);
        end
        feed_run--;
        feed_wait = feed_calm ? 0 : pick_wait();
      end
      if (!in_valid || in_took) begin
        if (feed_wait > 0) begin
          in_valid <= 1'b0;
          feed_wait--;
        end else if (tick_backlog.size() != 0) begin
          in_data <= tick_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stalls plus a long hold-off now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        sink_beats++;
        if (sink_run == 0) begin
          sink_run = $urandom_range(8, 64);
          sink_calm = ($urandom_range(0, 3) == 0);
        end
        sink_run--;
        sink_wait = sink_calm ? 0 : pick_wait();
        if (sink_beats % 5000 == 300)
          sink_wait = 90;
      end
      if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Predict on every accepted tick, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        due_results.push_back(master_tick(in_data));
      if (out_valid && out_ready) begin
        beats_checked++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none actual %h", $time, out_data);
        end else begin
          want_beat = due_results.pop_front();
          if (out_data.line_release !== want_beat.line_release)
            flag_field("line_release", want_beat.line_release, out_data.line_release);
          if (out_data.busy_res !== want_beat.busy_res)
            flag_field("busy_res", want_beat.busy_res, out_data.busy_res);
          if (out_data.done_res !== want_beat.done_res)
            flag_field("done_res", want_beat.done_res, out_data.done_res);
          if (out_data.presence_bit !== want_beat.presence_bit)
            flag_field("presence_bit", want_beat.presence_bit, out_data.presence_bit);
          if (out_data.read_data !== want_beat.read_data)
            flag_field("read_data", want_beat.read_data, out_data.read_data);
        end
      end
    end
    in_took <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("one_wire_master regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned seg_start;
    // power-on durations and bus state
    dur_cfg[owm_pkg::REG_RESET_LOW] = 10'd500;
    dur_cfg[owm_pkg::REG_PRESENCE_WAIT] = 10'd70;
    dur_cfg[owm_pkg::REG_RESET_RECOVER] = 10'd500;
    dur_cfg[owm_pkg::REG_WRITE_START] = 10'd10;
    dur_cfg[owm_pkg::REG_WRITE_HOLD] = 10'd50;
    dur_cfg[owm_pkg::REG_READ_LOW] = 10'd5;
    dur_cfg[owm_pkg::REG_READ_WAIT] = 10'd5;
    dur_cfg[owm_pkg::REG_READ_REST] = 10'd50;
    bus_phase = owm_pkg::PH_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    shift_reg = '0;
    presence_q = 1'b1;
    read_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default read timing straight out of reset
    add_tick(owm_pkg::OP_NONE, 8'hff, 1'b1);
    run_command(owm_pkg::OP_READ, 8'h00, LVL_RAND);
    wait_quiet();

    // zero durations behave as single-tick phases
    for (int r = 0; r < owm_pkg::NUM_CFG; r++)
      set_duration(owm_pkg::cfg_reg_t'(r), '0);
    add_tick(owm_pkg::OP_NONE, 8'h00, 1'b0);
    add_tick(owm_pkg::OP_NONE, 8'hff, 1'b1);
    run_command(owm_pkg::OP_RESET, 8'h00, LVL_LOW);
    run_command(owm_pkg::OP_RESET, 8'hff, LVL_HIGH);
    run_command(owm_pkg::OP_WRITE, 8'h00, LVL_RAND);
    run_command(owm_pkg::OP_WRITE, 8'hff, LVL_RAND);
    run_command(owm_pkg::OP_WRITE, 8'ha5, LVL_RAND);
    run_command(owm_pkg::OP_READ, 8'hff, LVL_LOW);
    run_command(owm_pkg::OP_READ, 8'h00, LVL_HIGH);
    run_command(owm_pkg::OP_READ, 8'h3c, LVL_RAND);
    noise_burst();
    wait_quiet();

    // small nonzero durations, mixed
    set_duration(owm_pkg::REG_RESET_LOW, 10'd1);
    set_duration(owm_pkg::REG_PRESENCE_WAIT, 10'd2);
    set_duration(owm_pkg::REG_RESET_RECOVER, 10'd3);
    set_duration(owm_pkg::REG_WRITE_START, 10'd1);
    set_duration(owm_pkg::REG_WRITE_HOLD, 10'd3);
    set_duration(owm_pkg::REG_READ_LOW, 10'd2);
    set_duration(owm_pkg::REG_READ_WAIT, 10'd1);
    set_duration(owm_pkg::REG_READ_REST, 10'd2);
    run_command(owm_pkg::OP_RESET, 8'h5a, LVL_HIGH);
    run_command(owm_pkg::OP_WRITE, 8'h81, LVL_RAND);
    add_tick(owm_pkg::OP_NONE, 8'h7e, 1'b0);
    run_command(owm_pkg::OP_READ, 8'h00, LVL_RAND);
    run_command(owm_pkg::OP_RESET, 8'h00, LVL_LOW);
    wait_quiet();

    // random settings, mostly framed commands, some loose noise
    base = ticks_sent;
    while (ticks_sent - base < RANDOM_TICKS) begin
      wait_quiet();
      for (int r = 0; r < owm_pkg::NUM_CFG; r++)
        set_duration(owm_pkg::cfg_reg_t'(r), pick_duration());
      seg_start = ticks_sent;
      while (ticks_sent - seg_start < SEGMENT_TICKS) begin
        if ($urandom_range(0, 9) == 0)
          noise_burst();
        else
          run_command(owm_pkg::opcode_t'($urandom_range(1, 3)), owm_pkg::BYTE_W'($urandom),
                      int'($urandom_range(0, 2)));
        repeat ($urandom_range(0, 2))
          add_tick(owm_pkg::OP_NONE, owm_pkg::BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    wait_quiet();

    if (mismatches == 0 && due_results.size() == 0)
      $display("one_wire_master regression: pass");
    else
      $display("one_wire_master regression: fail");
    $finish;
  end

endmodule
